// ----- rtl/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/mpfm_pkg.sv -----
package mpfm_pkg;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int FREQ_W = 24;
  localparam int TS_W   = 16;
  localparam int CNT_W  = 8;

  // rate * (count - 1) + dt / 2 needs 33 bits
  localparam int NUM_W  = 33;
  localparam int DIV_W  = 16;
  localparam int ITER_W = $clog2(NUM_W + 1);

  localparam logic [CNT_W-1:0]  FAST_COUNT = 8'd64;
  localparam logic [CNT_W-1:0]  MIN_COUNT  = 8'd2;
  localparam logic [FREQ_W-1:0] FREQ_MAX   = 24'hFFFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_RATE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE  = 2'd2;

  localparam logic [FREQ_W-1:0] RATE_RST   = 24'd131072;
  localparam logic [TS_W-1:0]   IDLE_RST   = 16'd8192;
  localparam logic [TS_W-1:0]   SAMPLE_RST = 16'd1638;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/mpfm_div.sv -----
module mpfm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mpfm_pkg::NUM_W-1:0] numerator,
  input  logic [mpfm_pkg::DIV_W-1:0] divisor,
  output logic [mpfm_pkg::NUM_W-1:0] quotient,
  output mpfm_pkg::div_stat_t        stat
);
  import mpfm_pkg::*;

  logic [NUM_W-1:0]  num_sh;
  logic [DIV_W-1:0]  div_r;
  logic [DIV_W-1:0]  rem;
  logic [ITER_W-1:0] iter;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              ge;

  // restoring division, one quotient bit per cycle, MSB first
  assign trial = {rem, num_sh[NUM_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = (trial >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        num_sh    <= numerator;
        div_r     <= divisor;
        rem       <= '0;
        iter      <= ITER_W'(NUM_W);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        num_sh   <= {num_sh[NUM_W-2:0], 1'b0};
        rem      <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        quotient <= {quotient[NUM_W-2:0], ge};
        iter     <= iter - 1'b1;
        if (iter == ITER_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/multichannel_pulse_frequency_meter.sv -----
// Per-channel reciprocal frequency meter.
// Input stream: s_tuser is the item kind (0 = captured edge, 1 = service poll),
// s_tdata carries the channel and a 16-bit timer value. Each input transfer
// gives exactly one result transfer on the m_ side: channel, stored frequency,
// edge total, age since the last update and the updated/zeroed/early flags.
// Configuration (rate, idle timeout, sample time) is written through the cfg
// channel, which is always ready; write it only while the block is idle.
// Flow: an edge or a non-measuring poll passes through ST_EVAL and ST_OUT
// before m_tvalid rises. A measuring poll adds ST_MUL (one multiply step),
// ST_START and ST_WAIT, where a bit-serial divider works through the 33-bit
// numerator bit by bit. s_tready is low while an item is in work, so a new
// item is taken only after the last one has reached the output register.
// The result sits in an output register; a new item is taken while it waits,
// and the block stalls only when a second result is ready before the first
// has been taken.
// Reset clears all channel state, loads the default configuration and drops
// m_tvalid.
module multichannel_pulse_frequency_meter #(
  parameter int CHANNELS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mpfm_pkg::IN_DATA_W-1:0]  s_tdata,  // channel[1:0], timestamp[17:2]
  input  logic                            s_tuser,  // mode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // channel_out[1:0], frequency[25:2], edges_seen[41:26], age[57:42]
  output logic [mpfm_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [mpfm_pkg::OUT_USER_W-1:0] m_tuser,  // updated, zeroed, early_request
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mpfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpfm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mpfm_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EVAL  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_START = 6'b001000,
    ST_WAIT  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t state;

  logic [FREQ_W-1:0] rate;
  logic [TS_W-1:0]   idle_timeout;
  logic [TS_W-1:0]   sample_time;

  logic [TS_W-1:0]   edge_total      [CHANNELS];
  logic [TS_W-1:0]   base_time       [CHANNELS];
  logic [CNT_W-1:0]  sample_count    [CHANNELS];
  logic [TS_W-1:0]   last_capture    [CHANNELS];
  logic [FREQ_W-1:0] frequency_store [CHANNELS];
  logic [TS_W-1:0]   last_update     [CHANNELS];

  logic              item_mode;
  logic [1:0]        item_ch;
  logic [TS_W-1:0]   item_ts;
  logic              item_ok;
  logic [CH_W-1:0]   idx;

  logic [CNT_W-1:0]  cnt_m1;
  logic [DIV_W-1:0]  dt_r;
  logic [31:0]       prod;
  logic              upd;
  logic              zer;
  logic              early;

  logic [1:0]        out_ch;
  logic [FREQ_W-1:0] out_freq;
  logic [TS_W-1:0]   out_edges;
  logic [TS_W-1:0]   out_age;
  logic              out_upd;
  logic              out_zer;
  logic              out_early;

  logic [CNT_W-1:0]  cur_sc;
  logic [TS_W-1:0]   cur_dt;
  logic [TS_W-1:0]   since_base;
  logic [TS_W-1:0]   since_upd;
  logic              fast_path;
  logic              slow_path;
  logic              idle_hit;

  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [NUM_W-1:0]  div_quo;
  div_stat_t         div_stat;
  logic [FREQ_W-1:0] q_sat;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);

  assign cur_sc     = sample_count[idx];
  assign cur_dt     = last_capture[idx] - base_time[idx];
  assign since_base = item_ts - base_time[idx];
  assign since_upd  = item_ts - last_update[idx];
  assign fast_path  = (cur_sc > FAST_COUNT);
  assign slow_path  = (cur_sc >= MIN_COUNT) && !fast_path && (since_base >= sample_time);
  assign idle_hit   = (cur_sc < MIN_COUNT) && (since_upd >= idle_timeout);

  assign div_start = (state == ST_START);
  assign div_num   = {1'b0, prod} + NUM_W'(dt_r[DIV_W-1:1]);
  assign q_sat     = (|div_quo[NUM_W-1:FREQ_W]) ? FREQ_MAX : div_quo[FREQ_W-1:0];

  mpfm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .numerator (div_num),
    .divisor   (dt_r),
    .quotient  (div_quo),
    .stat      (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rate         <= RATE_RST;
      idle_timeout <= IDLE_RST;
      sample_time  <= SAMPLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RATE:   rate         <= cfg_data;
        REG_IDLE:   idle_timeout <= cfg_data[TS_W-1:0];
        REG_SAMPLE: sample_time  <= cfg_data[TS_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        edge_total[i]      <= '0;
        base_time[i]       <= '0;
        sample_count[i]    <= '0;
        last_capture[i]    <= '0;
        frequency_store[i] <= '0;
        last_update[i]     <= '0;
      end
    end else begin
      // ST_OUT reloads the output register itself
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            item_mode <= s_tuser;
            item_ch   <= s_tdata[1:0];
            item_ts   <= s_tdata[17:2];
            item_ok   <= (32'(s_tdata[1:0]) < CHANNELS);
            idx       <= CH_W'(s_tdata[1:0]);
            upd       <= 1'b0;
            zer       <= 1'b0;
            early     <= 1'b0;
            state     <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          state <= ST_OUT;
          if (item_ok) begin
            if (!item_mode) begin
              last_capture[idx] <= item_ts;
              sample_count[idx] <= cur_sc + 1'b1;
              edge_total[idx]   <= edge_total[idx] + 1'b1;
              early             <= cur_sc[CNT_W-1];
              if (cur_sc == '0) begin
                base_time[idx] <= item_ts;
              end
            end else if (fast_path || slow_path) begin
              base_time[idx]    <= last_capture[idx];
              sample_count[idx] <= CNT_W'(1);
              cnt_m1            <= cur_sc - 1'b1;
              dt_r              <= cur_dt;
              // zero interval leaves frequency and update time alone
              if (cur_dt != '0) begin
                state <= ST_MUL;
              end
            end else if (idle_hit) begin
              sample_count[idx]    <= '0;
              frequency_store[idx] <= '0;
              last_update[idx]     <= item_ts;
              zer                  <= 1'b1;
            end
          end
        end
        ST_MUL: begin
          prod  <= 32'(rate) * 32'(cnt_m1);
          state <= ST_START;
        end
        ST_START: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_stat.done) begin
            frequency_store[idx] <= q_sat;
            last_update[idx]     <= item_ts;
            upd                  <= 1'b1;
            state                <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            out_ch    <= item_ch;
            out_freq  <= item_ok ? frequency_store[idx] : '0;
            out_edges <= item_ok ? edge_total[idx] : '0;
            out_age   <= item_ok ? since_upd : '0;
            out_upd   <= upd;
            out_zer   <= zer;
            out_early <= early;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {6'b0, out_age, out_edges, out_freq, out_ch};
  assign m_tuser = {out_early, out_zer, out_upd};

endmodule

// ----- rtl/mpfm_checker.sv -----
`include "assert_macros.svh"

module mpfm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [mpfm_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [mpfm_pkg::OUT_USER_W-1:0] m_tuser
);

  // a stalled result stays offered
  `ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

  // a stalled result keeps its payload
  `ASSERT_CLK(a_out_stable, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // an accepted item keeps the block busy for at least the next cycle
  `ASSERT_CLK(a_busy_after_accept, clk, rst, s_tvalid && s_tready |=> !s_tready, "ready right after an input transfer")

  // an idle block stays ready until an item comes
  `ASSERT_CLK(a_idle_stays, clk, rst, s_tready && !s_tvalid |=> s_tready, "ready dropped without an input transfer")

endmodule

bind multichannel_pulse_frequency_meter mpfm_checker u_mpfm_checker (.*);

// ----- verif/multichannel_pulse_frequency_meter_tb.sv -----
`timescale 1ns / 1ps

localparam logic MODE_EDGE = 1'b0;
localparam logic MODE_POLL = 1'b1;

typedef struct packed {
  logic [1:0]                  ch;
  logic [mpfm_pkg::FREQ_W-1:0] freq;
  logic [15:0]                 edges;
  logic [mpfm_pkg::TS_W-1:0]   age;
  logic                        upd;
  logic                        zer;
  logic                        early;
} meter_result_t;

class meter_scoreboard;
  localparam int NCH = 4;
  localparam logic [7:0] EARLY_COUNT = 8'd128;

  logic [mpfm_pkg::FREQ_W-1:0] rate;
  logic [15:0] idle_to;
  logic [15:0] samp_time;

  logic [15:0] edges     [NCH];
  logic [15:0] base      [NCH];
  logic [7:0]  count     [NCH];
  logic [15:0] capture   [NCH];
  logic [23:0] freq      [NCH];
  logic [15:0] upd_time  [NCH];

  meter_result_t expected[$];
  int errors;

  function new();
    rate      = mpfm_pkg::RATE_RST;
    idle_to   = mpfm_pkg::IDLE_RST;
    samp_time = mpfm_pkg::SAMPLE_RST;
    errors    = 0;
    for (int i = 0; i < NCH; i++) begin
      edges[i] = '0; base[i] = '0; count[i] = '0;
      capture[i] = '0; freq[i] = '0; upd_time[i] = '0;
    end
  endfunction

  function void write_reg(logic [1:0] idx, logic [23:0] val);
    case (idx)
      mpfm_pkg::REG_RATE:   rate = val;
      mpfm_pkg::REG_IDLE:   idle_to = val[15:0];
      mpfm_pkg::REG_SAMPLE: samp_time = val[15:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return expected.size();
  endfunction

  // reciprocal measurement over the edges since base; 0 when the interval is empty
  function logic measure(int c, logic [15:0] ts);
    logic [15:0] dt;
    logic [7:0]  periods;
    logic [63:0] q;
    dt = capture[c] - base[c];
    periods = count[c] - 8'd1;
    base[c] = capture[c];
    count[c] = 8'd1;
    if (dt == 16'd0)
      return 1'b0;
    q = (64'(rate) * 64'(periods) + 64'(dt >> 1)) / 64'(dt);
    freq[c] = (q > 64'(mpfm_pkg::FREQ_MAX)) ? mpfm_pkg::FREQ_MAX : q[23:0];
    upd_time[c] = ts;
    return 1'b1;
  endfunction

  function void note_item(logic mode, logic [1:0] c, logic [15:0] ts);
    meter_result_t r;
    logic [7:0]  sc;
    logic [15:0] span;
    r = '0;
    r.ch = c;
    sc = count[c];
    if (mode == MODE_EDGE) begin
      capture[c] = ts;
      count[c] = sc + 8'd1;
      if (sc == 8'd0)
        base[c] = ts;
      r.early = (sc >= EARLY_COUNT);
      edges[c] = edges[c] + 16'd1;
    end else if (sc > mpfm_pkg::FAST_COUNT) begin
      r.upd = measure(c, ts);
    end else if (sc < mpfm_pkg::MIN_COUNT) begin
      span = ts - upd_time[c];
      if (span >= idle_to) begin
        count[c] = '0;
        freq[c] = '0;
        upd_time[c] = ts;
        r.zer = 1'b1;
      end
    end else begin
      span = ts - base[c];
      if (span >= samp_time)
        r.upd = measure(c, ts);
    end
    r.freq  = freq[c];
    r.edges = edges[c];
    r.age   = ts - upd_time[c];
    expected.push_back(r);
  endfunction

  function void note_error(string msg);
    errors++;
    if (errors <= 10)
      $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  function void check_result(logic [63:0] data, logic [2:0] user);
    meter_result_t got, want;
    got.ch    = data[1:0];
    got.freq  = data[25:2];
    got.edges = data[41:26];
    got.age   = data[57:42];
    got.upd   = user[0];
    got.zer   = user[1];
    got.early = user[2];
    if (expected.size() == 0) begin
      note_error($sformatf("result with nothing pending, ch=%0d", got.ch));
      return;
    end
    want = expected.pop_front();
    if (got.ch !== want.ch || got.freq !== want.freq || got.edges !== want.edges ||
        got.age !== want.age || got.upd !== want.upd || got.zer !== want.zer ||
        got.early !== want.early)
      note_error($sformatf(
        "exp ch=%0d freq=%0d edges=%0d age=%0d u/z/e=%b%b%b, got ch=%0d freq=%0d edges=%0d age=%0d u/z/e=%b%b%b",
        want.ch, want.freq, want.edges, want.age, want.upd, want.zer, want.early,
        got.ch, got.freq, got.edges, got.age, got.upd, got.zer, got.early));
  endfunction
endclass

module multichannel_pulse_frequency_meter_tb;
  import mpfm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int LIMIT = 1_500_000;
  localparam int ITEMS_PER_PHASE = 330;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  meter_scoreboard sb = new;

  int cycles = 0;
  int src_mode = 0;   // 0: back to back, 1: some gaps, 2: many gaps
  int sink_mode = 0;  // 0: always ready, 1: some stalls, 2: many stalls
  int hold_cnt = 0;
  logic [15:0] now_ts = '0;
  int burst_goal [4] = '{0, 0, 0, 0};
  int burst_done [4] = '{0, 0, 0, 0};

  multichannel_pulse_frequency_meter #(.CHANNELS(4)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result sink with random stalls, mostly short
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else if (sink_mode == 0 || $urandom_range(99) >= sink_mode * 25) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b0;
      hold_cnt <= ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata, m_tuser);
  end

  // valid stays high across back-to-back transfers
  task automatic send_item(logic mode, logic [1:0] c, logic [15:0] ts);
    int g;
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {6'd0, ts, c};
    do @(posedge clk); while (!s_tready);
    sb.note_item(mode, c, ts);
    gap = 0;
    if (src_mode != 0) begin
      g = $urandom_range(99);
      if (g < src_mode * 25)
        gap = (g < 3) ? $urandom_range(20, 80) : $urandom_range(1, 4);
    end
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic program_meter(logic [23:0] rate, logic [23:0] idle, logic [23:0] samp,
                               bit poke_unused);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [23:0] val [4];
    int n;
    idx = '{REG_RATE, REG_IDLE, REG_SAMPLE, REG_UNUSED};
    val = '{rate, idle, samp, 24'($urandom)};
    n = poke_unused ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  // edge bursts on interleaved channels, each closed by a poll, plus stray polls and noise
  task automatic run_random(int n);
    int pick;
    int g;
    int c;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        send_item(1'($urandom_range(1)), 2'($urandom_range(3)), 16'($urandom));
      end else begin
        c = $urandom_range(3);
        g = $urandom_range(99);
        now_ts += 16'((g < 75) ? $urandom_range(0, 8) :
                      (g < 97) ? $urandom_range(9, 300) : $urandom_range(301, 40000));
        if (pick < 15 || burst_done[c] >= burst_goal[c]) begin
          send_item(MODE_POLL, 2'(c), now_ts);
          if (burst_done[c] >= burst_goal[c]) begin
            g = $urandom_range(99);
            burst_goal[c] = (g < 40) ? $urandom_range(1) :
                            (g < 75) ? $urandom_range(2, 64) :
                            (g < 90) ? $urandom_range(65, 140) : $urandom_range(141, 300);
            burst_done[c] = 0;
          end
        end else begin
          send_item(MODE_EDGE, 2'(c), now_ts);
          burst_done[c]++;
        end
      end
    end
  endtask

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, reset configuration
    src_mode  = 1;
    sink_mode = 1;
    send_item(MODE_POLL, 2'd0, 16'd0);       // idle, timeout not reached
    send_item(MODE_POLL, 2'd1, 16'hFFFF);    // idle timeout, channel zeroed
    send_item(MODE_EDGE, 2'd2, 16'hFFFF);    // base set by first edge
    send_item(MODE_EDGE, 2'd2, 16'h0010);    // capture wraps past zero
    send_item(MODE_POLL, 2'd2, 16'h0700);
    send_item(MODE_EDGE, 2'd3, 16'd100);     // zero interval
    send_item(MODE_EDGE, 2'd3, 16'd100);
    send_item(MODE_POLL, 2'd3, 16'd2000);
    send_item(MODE_POLL, 2'd3, 16'd2001);
    send_item(MODE_EDGE, 2'd0, 16'd500);     // sample time not yet, then exactly reached
    send_item(MODE_EDGE, 2'd0, 16'd600);
    send_item(MODE_POLL, 2'd0, 16'd700);
    send_item(MODE_POLL, 2'd0, 16'd2138);
    send_item(MODE_EDGE, 2'd1, 16'hAAAA);
    send_item(MODE_EDGE, 2'd1, 16'hAAAB);
    send_item(MODE_POLL, 2'd1, 16'h5555);
    send_item(MODE_EDGE, 2'd2, 16'h5555);
    send_item(MODE_POLL, 2'd2, 16'hAAAA);
    s_tvalid <= 1'b0;

    wait_idle();
    program_meter(24'hFFFFFF, 24'd1, 24'd1, 1'b0);
    src_mode  = 0;
    sink_mode = 0;
    run_random(ITEMS_PER_PHASE);
    s_tvalid <= 1'b0;

    wait_idle();
    program_meter(24'd1, 24'hFFFFFF, 24'h00FFFF, 1'b1);
    src_mode  = 1;
    sink_mode = 1;
    run_random(ITEMS_PER_PHASE);
    s_tvalid <= 1'b0;

    wait_idle();
    program_meter(24'd0, 24'd0, 24'd0, 1'b0);
    src_mode  = 2;
    sink_mode = 2;
    run_random(ITEMS_PER_PHASE);
    s_tvalid <= 1'b0;

    wait_idle();
    program_meter(24'($urandom), 24'($urandom), 24'($urandom), 1'b0);
    src_mode  = 1;
    sink_mode = 2;
    run_random(ITEMS_PER_PHASE);
    s_tvalid <= 1'b0;

    wait_idle();
    program_meter(24'($urandom_range(1000, 500000)), 24'($urandom_range(100, 3000)),
                  24'($urandom_range(50, 2000)), 1'b0);
    src_mode  = 2;
    sink_mode = 1;
    run_random(ITEMS_PER_PHASE);
    s_tvalid <= 1'b0;

    wait_idle();
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
